FILE: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the stream find-and-replace block
// no dependencies
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BURST_BYTES     = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 64;

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

    typedef logic [MAX_PATTERN-1:0][7:0]     t_pattern;
    typedef logic [MAX_REPLACEMENT-1:0][7:0] t_replacement;

    // active configuration, lengths already clamped
    typedef struct packed {
        t_pattern              pattern;
        logic [LEN_W-1:0]      plen;
        t_replacement          replacement;
        logic [LEN_W-1:0]      rlen;
    } t_cfg;

    // results caused by one input transaction, first byte in entry 0
    typedef struct packed {
        logic [BURST_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]            count;
    } t_burst;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] cap);
        clamp_len = (len > cap) ? cap : len;
    endfunction

endpackage

FILE: hw/rtl/sfr_cfg_regs.sv
`timescale 1ns / 1ps
// configuration registers: pattern, replacement and their lengths
// depends on sfr_pkg
module sfr_cfg_regs import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg,
    output logic                  o_plen_wr
);

    logic [63:0]      r_pattern;
    logic [LEN_W-1:0] r_plen;
    logic [63:0]      r_replacement;
    logic [LEN_W-1:0] r_rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_plen        <= '0;
            r_replacement <= '0;
            r_rlen        <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_PATTERN_BYTES:      r_pattern     <= i_wr_data;
                REG_PATTERN_LENGTH:     r_plen        <= i_wr_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  r_replacement <= i_wr_data;
                REG_REPLACEMENT_LENGTH: r_rlen        <= i_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_plen_wr = i_wr_en && (i_wr_index == REG_PATTERN_LENGTH);

    always_comb begin
        o_cfg.pattern     = r_pattern;
        o_cfg.plen        = clamp_len(r_plen, LEN_W'(MAX_PATTERN));
        o_cfg.replacement = r_replacement;
        o_cfg.rlen        = clamp_len(r_rlen, LEN_W'(MAX_REPLACEMENT));
    end

endmodule

FILE: hw/rtl/sfr_window.sv
`timescale 1ns / 1ps
// match window: holds the unmatched tail of the line, compares it with the
// pattern and works out the burst of result bytes for each input byte
// depends on sfr_pkg
module sfr_window import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_clear,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eol,
    output t_burst     o_burst
);

    logic [MAX_PATTERN-1:0][7:0] r_win;
    logic [LEN_W-1:0]            r_fill;

    logic [MAX_PATTERN-1:0][7:0] n_win;
    logic [LEN_W-1:0]            n_fill;

    logic [MAX_PATTERN-1:0][7:0] win_wr;
    logic [MAX_PATTERN-1:0][7:0] win_shift;
    logic [LEN_W-1:0]            fill_base;
    logic [LEN_W-1:0]            fill_inc;
    logic                        full;
    logic                        hit;

    always_comb begin
        fill_base = (r_fill >= i_cfg.plen) ? '0 : r_fill;
        win_wr    = r_win;
        win_wr[fill_base[2:0]] = i_byte;
        fill_inc  = fill_base + LEN_W'(1);
        full      = (fill_inc == i_cfg.plen);

        hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((LEN_W'(k) < i_cfg.plen) && (win_wr[k] != i_cfg.pattern[k]))
                hit = 1'b0;
        end

        for (int k = 0; k < MAX_PATTERN - 1; k++)
            win_shift[k] = win_wr[k+1];
        win_shift[MAX_PATTERN-1] = win_wr[MAX_PATTERN-1];
    end

    // results and next state for the transaction on the input
    always_comb begin
        o_burst = '0;
        n_win   = r_win;
        n_fill  = r_fill;
        if (i_eol) begin
            // flush the window, then the newline
            for (int k = 0; k < BURST_BYTES; k++) begin
                if (LEN_W'(k) < r_fill)
                    o_burst.bytes[k] = r_win[k];
                else if (LEN_W'(k) == r_fill)
                    o_burst.bytes[k] = NEWLINE;
            end
            o_burst.count = r_fill + LEN_W'(1);
            n_fill        = '0;
        end else if (i_cfg.plen == '0) begin
            o_burst.bytes[0] = i_byte;
            o_burst.count    = LEN_W'(1);
        end else if (!full) begin
            n_win  = win_wr;
            n_fill = fill_inc;
        end else if (hit) begin
            o_burst.bytes = i_cfg.replacement;
            o_burst.count = i_cfg.rlen;
            n_win         = win_wr;
            n_fill        = '0;
        end else begin
            o_burst.bytes[0] = win_wr[0];
            o_burst.count    = LEN_W'(1);
            n_win            = win_shift;
            n_fill           = i_cfg.plen - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

FILE: hw/rtl/sfr_burst_out.sv
`timescale 1ns / 1ps
// output register: holds one burst of result bytes and sends them one per
// transaction, flagging the last byte of each burst
// depends on sfr_pkg
module sfr_burst_out import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_free,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [BURST_BYTES-1:0][7:0] r_bytes;
    logic [LEN_W-1:0]            r_rem;
    logic                        send;

    assign o_tvalid = (r_rem != '0);
    assign o_tdata  = r_bytes[0];
    assign o_tlast  = (r_rem == LEN_W'(1));
    assign send     = o_tvalid && i_tready;
    // can load this cycle if empty or the last byte leaves now
    assign o_free   = (r_rem == '0) || (o_tlast && i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_burst.count;
        end else if (send) begin
            r_rem <= r_rem - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
        end else if (send) begin
            r_bytes <= {8'd0, r_bytes[BURST_BYTES-1:1]};
        end
    end

endmodule

FILE: hw/rtl/stream_find_replace.sv
`timescale 1ns / 1ps
// latency: the first result of an accepted byte is on the output the next cycle
// throughput: one input transaction per cycle while each gives at most one result and the
//   output is ready; a transaction giving n results (up to 8) holds the input until its last
//   result leaves the single output burst register
// reset: synchronous active low; clears the window fill, the output register and
//   all configuration registers (pattern length zero passes text through)
module stream_find_replace import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] text_byte
    input  logic                  i_s_axis_tlast,   // line_end
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic                  o_m_axis_tlast,   // last_of_run
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   cfg;
    t_burst burst;
    logic   plen_wr;
    logic   out_free;
    logic   in_accept;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = out_free;
    assign in_accept       = i_s_axis_tvalid && out_free;

    sfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg),
        .o_plen_wr  (plen_wr)
    );

    sfr_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_clear  (plen_wr),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_eol    (i_s_axis_tlast),
        .o_burst  (burst)
    );

    sfr_burst_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_burst  (burst),
        .o_free   (out_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
